@@ rtl/ptff_pkg.sv @@
// ----------------------------------------------------------------------------
// ptff_pkg
// Shared types and constants for the permutation table with flag filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ptff_pkg;

  localparam int DEF_MAX_ELEMENTS = 1024;
  localparam int DEF_FLAG_BITS    = 32;

  localparam int FUNC_W = 3;
  localparam int MASK_W = 32;

  localparam logic [FUNC_W-1:0] FN_SWAP  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SET   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd2;
  localparam logic [FUNC_W-1:0] FN_ZERO  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_RDVIS = 3'd4;
  localparam logic [FUNC_W-1:0] FN_RDPHY = 3'd5;

  // Command class of an incoming beat
  typedef enum logic [2:0] {
    K_SWAP = 3'd0,
    K_FLAG = 3'd1,
    K_VIS  = 3'd2,
    K_PHYS = 3'd3,
    K_BAD  = 3'd4
  } kind_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept;
    logic init_step;
    logic swap_w1;
    logic swap_w2;
    logic flag_rd;
    logic flag_w;
    logic scan_rd;
    logic scan_chk;
    logic out_load;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    kind_t in_kind;
    logic  in_err;
    logic  sweep_last;
    logic  hit;
    logic  out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/ptff_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptff_ctrl
// Command sequencer: init sweep, per-command memory steps, flag scan, result.
// ----------------------------------------------------------------------------
`default_nettype none

module ptff_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ptff_pkg::sts_t sts,
  output ptff_pkg::cmd_t     cmd
);
  import ptff_pkg::*;

  typedef enum logic [8:0] {
    S_INIT   = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_SWAP1  = 9'b000000100,
    S_SWAP2  = 9'b000001000,
    S_FLRD   = 9'b000010000,
    S_FLWR   = 9'b000100000,
    S_SCAN   = 9'b001000000,
    S_CHECK  = 9'b010000000,
    S_RESULT = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:   if (sts.sweep_last) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          if (sts.in_err) begin
            state_next = S_RESULT;
          end else begin
            unique case (sts.in_kind)
              K_SWAP:  state_next = S_SWAP1;
              K_FLAG:  state_next = S_FLRD;
              K_VIS:   state_next = S_SCAN;
              default: state_next = S_RESULT;
            endcase
          end
        end
      end
      S_SWAP1:  state_next = S_SWAP2;
      S_SWAP2:  state_next = S_RESULT;
      S_FLRD:   state_next = S_FLWR;
      S_FLWR:   state_next = S_RESULT;
      S_SCAN:   state_next = S_CHECK;
      S_CHECK:  state_next = sts.hit ? S_RESULT : S_SCAN;
      S_RESULT: if (sts.out_free) state_next = S_IDLE;
      default:  state_next = S_INIT;
    endcase
    // a size write restarts the table sweep
    if (cfg_we) state_next = S_INIT;
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.accept    = (state == S_IDLE) && in_valid;
    cmd.init_step = (state == S_INIT);
    cmd.swap_w1   = (state == S_SWAP1);
    cmd.swap_w2   = (state == S_SWAP2);
    cmd.flag_rd   = (state == S_FLRD);
    cmd.flag_w    = (state == S_FLWR);
    cmd.scan_rd   = (state == S_SCAN);
    cmd.scan_chk  = (state == S_CHECK);
    cmd.out_load  = (state == S_RESULT) && sts.out_free;
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> !in_ready)
    else $error("accepted a beat and stayed ready");

  a_swap_pair: assert property (@(posedge clk) disable iff (rst)
    (cmd.swap_w1 && !cfg_we) |=> cmd.swap_w2)
    else $error("swap first write not followed by second");

  a_flag_pair: assert property (@(posedge clk) disable iff (rst)
    (cmd.flag_rd && !cfg_we) |=> cmd.flag_w)
    else $error("flag read not followed by write");

endmodule

`default_nettype wire

@@ rtl/ptff_dp.sv @@
// ----------------------------------------------------------------------------
// ptff_dp
// Tables, element count, visible count, command registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptff_dp #(
  parameter int MAX_ELEMENTS = ptff_pkg::DEF_MAX_ELEMENTS,
  parameter int FLAG_BITS    = ptff_pkg::DEF_FLAG_BITS,
  localparam int IW = $clog2(MAX_ELEMENTS),
  localparam int CW = $clog2(MAX_ELEMENTS + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [CW-1:0]               cfg_data,
  input  wire logic [ptff_pkg::FUNC_W-1:0] func,
  input  wire logic [IW-1:0]               left_position,
  input  wire logic [IW-1:0]               right_position,
  input  wire logic [IW-1:0]               element_id,
  input  wire logic [ptff_pkg::MASK_W-1:0] flag_mask,
  input  wire logic [IW-1:0]               query_position,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             status,
  output logic [IW-1:0]                    element_value,
  output logic [CW-1:0]                    visible_total,
  input  wire ptff_pkg::cmd_t              cmd,
  output ptff_pkg::sts_t                   sts
);
  import ptff_pkg::*;

  localparam int WW = (FLAG_BITS > MASK_W) ? FLAG_BITS : MASK_W;
  localparam logic [CW-1:0] MAXC = CW'(MAX_ELEMENTS);
  localparam logic [IW-1:0] LASTI = IW'(MAX_ELEMENTS - 1);

  logic [IW-1:0]        ea_mem  [MAX_ELEMENTS];
  logic [IW-1:0]        soe_mem [MAX_ELEMENTS];
  logic [FLAG_BITS-1:0] fl_mem  [MAX_ELEMENTS];

  logic [CW-1:0]        count;
  logic [CW-1:0]        vis;
  logic [IW-1:0]        sw_ptr;
  logic [IW-1:0]        ptr;
  logic [IW-1:0]        rank;

  logic [FUNC_W-1:0]    func_q;
  logic [IW-1:0]        left_q, right_q, query_q;
  logic [FLAG_BITS-1:0] mask_q;
  logic                 err_q;
  kind_t                kind_q;

  logic [IW-1:0]        ea_a, ea_b, soe_d;
  logic [FLAG_BITS-1:0] fl_a, fl_b;
  logic [FLAG_BITS-1:0] new_flags;

  logic [WW-1:0]        mask_wide;
  kind_t                kind;
  logic                 err;
  logic                 zero_hit;

  assign mask_wide = WW'(flag_mask);

  // decode of the beat on the input
  always_comb begin
    unique case (func) inside
      FN_SWAP:                     kind = K_SWAP;
      FN_SET, FN_CLEAR, FN_ZERO:   kind = K_FLAG;
      FN_RDVIS:                    kind = K_VIS;
      FN_RDPHY:                    kind = K_PHYS;
      default:                     kind = K_BAD;
    endcase
    unique case (kind)
      K_SWAP:  err = (CW'(left_position) >= count) || (CW'(right_position) >= count);
      K_FLAG:  err = CW'(element_id) >= count;
      K_VIS:   err = CW'(query_position) >= vis;
      K_PHYS:  err = CW'(query_position) >= count;
      default: err = 1'b1;
    endcase
  end

  assign zero_hit = (fl_a == '0) && (rank == query_q);

  always_comb begin
    sts            = '0;
    sts.in_kind    = kind;
    sts.in_err     = err;
    sts.sweep_last = (sw_ptr == LASTI);
    sts.hit        = zero_hit;
    sts.out_free   = !out_valid || out_ready;
  end

  always_comb begin
    case (func_q)
      FN_SET:   new_flags = fl_a | mask_q;
      FN_CLEAR: new_flags = fl_a & ~mask_q;
      FN_ZERO:  new_flags = '0;
      default:  new_flags = fl_a;
    endcase
  end

  // count, visible count, sweep pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      vis    <= '0;
      sw_ptr <= '0;
    end else if (cfg_we) begin
      count  <= (cfg_data > MAXC) ? MAXC : cfg_data;
      vis    <= (cfg_data > MAXC) ? MAXC : cfg_data;
      sw_ptr <= '0;
    end else begin
      if (cmd.init_step) sw_ptr <= sw_ptr + IW'(1);
      if (cmd.flag_w) begin
        if (fl_a == '0 && new_flags != '0) vis <= vis - CW'(1);
        else if (fl_a != '0 && new_flags == '0) vis <= vis + CW'(1);
      end
    end
  end

  // command registers and scan pointer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_q  <= func;
      left_q  <= left_position;
      right_q <= right_position;
      query_q <= query_position;
      mask_q  <= mask_wide[FLAG_BITS-1:0];
      err_q   <= err;
      kind_q  <= kind;
      ptr     <= '0;
      rank    <= '0;
    end else if (cmd.scan_chk && !zero_hit) begin
      ptr <= ptr + IW'(1);
      if (fl_a == '0) rank <= rank + IW'(1);
    end
  end

  // element table: reads at two addresses, one write
  always_ff @(posedge clk) begin
    if (cmd.init_step) begin
      ea_mem[sw_ptr] <= sw_ptr;
    end else if (cmd.swap_w1) begin
      ea_mem[left_q] <= ea_b;
    end else if (cmd.swap_w2) begin
      ea_mem[right_q] <= ea_a;
    end
    if (cmd.accept) begin
      ea_a <= ea_mem[(func == FN_SWAP) ? left_position : query_position];
      ea_b <= ea_mem[right_position];
    end else if (cmd.scan_chk && zero_hit) begin
      ea_a <= ea_mem[ptr];
    end
  end

  // inverse map
  always_ff @(posedge clk) begin
    if (cmd.init_step) begin
      soe_mem[sw_ptr] <= sw_ptr;
    end else if (cmd.swap_w1) begin
      soe_mem[ea_b] <= left_q;
    end else if (cmd.swap_w2) begin
      soe_mem[ea_a] <= right_q;
    end
    if (cmd.accept) soe_d <= soe_mem[element_id];
  end

  // flag words
  always_ff @(posedge clk) begin
    if (cmd.init_step) begin
      fl_mem[sw_ptr] <= '0;
    end else if (cmd.swap_w1) begin
      fl_mem[left_q] <= fl_b;
    end else if (cmd.swap_w2) begin
      fl_mem[right_q] <= fl_a;
    end else if (cmd.flag_w) begin
      fl_mem[soe_d] <= new_flags;
    end
    if (cmd.accept) begin
      fl_a <= fl_mem[left_position];
      fl_b <= fl_mem[right_position];
    end else if (cmd.flag_rd) begin
      fl_a <= fl_mem[soe_d];
    end else if (cmd.scan_rd) begin
      fl_a <= fl_mem[ptr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status        <= err_q;
      element_value <= (!err_q && (kind_q == K_VIS || kind_q == K_PHYS)) ? ea_a : '0;
      visible_total <= vis;
    end
  end

  a_vis_le_count: assert property (@(posedge clk) disable iff (rst)
    vis <= count)
    else $error("visible count above element count");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_chk |-> (CW'(ptr) < count))
    else $error("flag scan ran past element count");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten");

endmodule

`default_nettype wire

@@ rtl/permutation_table_with_flag_filter.sv @@
// ----------------------------------------------------------------------------
// permutation_table_with_flag_filter
// Permutation of element ids over slots with per-slot flag words.
// ----------------------------------------------------------------------------
// After reset and after every element_count write the block sweeps all
// MAX_ELEMENTS table entries, one per cycle, and takes no command beat until
// done. Once a beat is accepted, read physical and errors go straight to
// the result state; a swap writes its two slots (S_SWAP1, S_SWAP2); a flag
// set/clear/zero reads, then writes the flag word (S_FLRD, S_FLWR); a read
// visible alternates S_SCAN and S_CHECK, walking the flag words one slot at
// a time through the flag memory's read port until the rank is found. The
// result register lets a new beat be accepted while the last result waits;
// a command that finishes while that result is still held stalls until taken.
`default_nettype none

module permutation_table_with_flag_filter #(
  parameter int MAX_ELEMENTS = ptff_pkg::DEF_MAX_ELEMENTS,
  parameter int FLAG_BITS    = ptff_pkg::DEF_FLAG_BITS,
  localparam int IW = $clog2(MAX_ELEMENTS),
  localparam int CW = $clog2(MAX_ELEMENTS + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [CW-1:0]               cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [ptff_pkg::FUNC_W-1:0] func,
  input  wire logic [IW-1:0]               left_position,
  input  wire logic [IW-1:0]               right_position,
  input  wire logic [IW-1:0]               element_id,
  input  wire logic [ptff_pkg::MASK_W-1:0] flag_mask,
  input  wire logic [IW-1:0]               query_position,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             status,
  output logic [IW-1:0]                    element_value,
  output logic [CW-1:0]                    visible_total
);
  import ptff_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ptff_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptff_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .FLAG_BITS    (FLAG_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .func           (func),
    .left_position  (left_position),
    .right_position (right_position),
    .element_id     (element_id),
    .flag_mask      (flag_mask),
    .query_position (query_position),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .element_value  (element_value),
    .visible_total  (visible_total),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives command beats into the permutation table with flag filter, predicts
// each result from a software copy of the slot and flag tables, and compares
// every result beat field by field under random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import ptff_pkg::*;

  localparam int SLOTS = 1024;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam logic [2:0] FN_RSVD6 = 3'd6;
  localparam logic [2:0] FN_RSVD7 = 3'd7;

  typedef struct {
    logic [2:0]  fn;
    logic [9:0]  lpos;
    logic [9:0]  rpos;
    logic [9:0]  eid;
    logic [31:0] mask;
    logic [9:0]  qpos;
  } cmd_s;

  typedef struct {
    logic        st;
    logic [9:0]  val;
    logic [10:0] tot;
  } rsp_s;

  // Mirror of the slot tables; computes the response to each accepted command.
  class flag_table_sb;
    int unsigned count;
    logic [9:0]  elem_at[SLOTS];
    logic [9:0]  slot_of[SLOTS];
    logic [31:0] flags[SLOTS];
    rsp_s        expected_q[$];
    int          errors;

    function new();
      errors = 0;
      configure(0);
    endfunction

    function void configure(int unsigned v);
      int unsigned w;
      w = v & 32'h7FF;
      count = (w > SLOTS) ? SLOTS : w;
      for (int i = 0; i < SLOTS; i++) begin
        elem_at[i] = 10'(i);
        slot_of[i] = 10'(i);
        flags[i] = '0;
      end
    endfunction

    function int unsigned visible_total();
      int unsigned t;
      t = 0;
      for (int i = 0; i < count; i++) if (flags[i] == 0) t++;
      return t;
    endfunction

    function void note_input(cmd_s c);
      rsp_s        r;
      logic [9:0]  te;
      logic [31:0] tf;
      int unsigned rank;
      r.st = 1'b0;
      r.val = '0;
      case (c.fn)
        FN_SWAP: begin
          if (c.lpos >= count || c.rpos >= count) r.st = 1'b1;
          else begin
            te = elem_at[c.lpos];
            tf = flags[c.lpos];
            elem_at[c.lpos] = elem_at[c.rpos];
            elem_at[c.rpos] = te;
            flags[c.lpos] = flags[c.rpos];
            flags[c.rpos] = tf;
            slot_of[elem_at[c.lpos]] = c.lpos;
            slot_of[elem_at[c.rpos]] = c.rpos;
          end
        end
        FN_SET, FN_CLEAR, FN_ZERO: begin
          if (c.eid >= count) r.st = 1'b1;
          else if (c.fn == FN_SET) flags[slot_of[c.eid]] |= c.mask;
          else if (c.fn == FN_CLEAR) flags[slot_of[c.eid]] &= ~c.mask;
          else flags[slot_of[c.eid]] = '0;
        end
        FN_RDVIS: begin
          r.st = 1'b1;
          rank = 0;
          for (int i = 0; i < count; i++) begin
            if (flags[i] == 0) begin
              if (rank == c.qpos) begin
                r.st = 1'b0;
                r.val = elem_at[i];
              end
              rank++;
            end
          end
        end
        FN_RDPHY: begin
          if (c.qpos >= count) r.st = 1'b1;
          else r.val = elem_at[c.qpos];
        end
        default: r.st = 1'b1;
      endcase
      r.tot = 11'(visible_total());
      expected_q.push_back(r);
    endfunction

    function void check_result(rsp_s a);
      rsp_s e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat st=%0d val=%0d tot=%0d",
                 $time, a.st, a.val, a.tot);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (a.st !== e.st) begin
        $display("%0t: status exp %0d got %0d", $time, e.st, a.st);
        errors++;
      end
      if (a.val !== e.val) begin
        $display("%0t: element_value exp %0d got %0d", $time, e.val, a.val);
        errors++;
      end
      if (a.tot !== e.tot) begin
        $display("%0t: visible_total exp %0d got %0d", $time, e.tot, a.tot);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [10:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  func;
  logic [9:0]  left_position;
  logic [9:0]  right_position;
  logic [9:0]  element_id;
  logic [31:0] flag_mask;
  logic [9:0]  query_position;
  logic        out_valid;
  logic        out_ready;
  logic        status;
  logic [9:0]  element_value;
  logic [10:0] visible_total;

  flag_table_sb sb;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           quiet_cycles;

  permutation_table_with_flag_filter dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .func(func),
    .left_position(left_position), .right_position(right_position),
    .element_id(element_id), .flag_mask(flag_mask),
    .query_position(query_position), .out_valid(out_valid),
    .out_ready(out_ready), .status(status), .element_value(element_value),
    .visible_total(visible_total)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side: check accepted beats, randomize out_ready.
  always @(posedge clk) begin
    rsp_s a;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        a.st = status;
        a.val = element_value;
        a.tot = visible_total;
        sb.check_result(a);
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_cmd(cmd_s c);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    func           <= c.fn;
    left_position  <= c.lpos;
    right_position <= c.rpos;
    element_id     <= c.eid;
    flag_mask      <= c.mask;
    query_position <= c.qpos;
    do @(posedge clk); while (!in_ready);
    sb.note_input(c);
  endtask

  task automatic send_fields(logic [2:0] fn, int lp, int rp, int eid,
                             logic [31:0] mask, int qp);
    cmd_s c;
    c.fn = fn; c.lpos = 10'(lp); c.rpos = 10'(rp); c.eid = 10'(eid);
    c.mask = mask; c.qpos = 10'(qp);
    send_cmd(c);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_count(int unsigned v);
    drain();
    repeat (20) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= 11'(v);
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.configure(v);
  endtask

  function automatic int pick_arg(int unsigned bound);
    if (bound == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
    return $urandom_range(0, bound - 1);
  endfunction

  function automatic cmd_s random_cmd();
    cmd_s c;
    int   r;
    r = $urandom_range(0, 99);
    if (r < 4) c.fn = $urandom_range(0, 1) ? FN_RSVD6 : FN_RSVD7;
    else c.fn = 3'($urandom_range(0, 5));
    c.lpos = 10'(pick_arg(sb.count));
    c.rpos = 10'(pick_arg(sb.count));
    c.eid  = 10'(pick_arg(sb.count));
    c.qpos = (c.fn == FN_RDVIS) ? 10'(pick_arg(sb.visible_total() + 1))
                                : 10'(pick_arg(sb.count));
    case ($urandom_range(0, 3))
      0: c.mask = 32'h1 << $urandom_range(0, 31);
      1: c.mask = 32'hFFFF_FFFF;
      default: c.mask = $urandom();
    endcase
    return c;
  endfunction

  initial begin
    int counts[8];
    int sent;
    int total;
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0; cfg_data = '0;
    in_valid = 1'b0; func = '0; left_position = '0; right_position = '0;
    element_id = '0; flag_mask = '0; query_position = '0;
    send_idle_pct = 36;
    recv_idle_pct = 48;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty table: everything errors
    send_fields(FN_RDPHY, 0, 0, 0, 0, 0);
    send_fields(FN_RDVIS, 0, 0, 0, 0, 0);

    write_count(8);
    send_fields(FN_SWAP, 0, 7, 0, 0, 0);
    send_fields(FN_SWAP, 3, 3, 0, 0, 0);        // self swap
    send_fields(FN_SET, 0, 0, 2, 32'hFFFF_FFFF, 0);
    send_fields(FN_SET, 0, 0, 5, 32'h1, 0);
    send_fields(FN_RDVIS, 0, 0, 0, 0, 0);
    send_fields(FN_RDVIS, 0, 0, 0, 0, 5);
    send_fields(FN_RDVIS, 0, 0, 0, 0, 6);       // rank past visible count
    send_fields(FN_RDPHY, 0, 0, 0, 0, 7);
    send_fields(FN_RDPHY, 0, 0, 0, 0, 8);       // slot past count
    send_fields(FN_CLEAR, 0, 0, 2, 32'h0000_FFFF, 0);
    send_fields(FN_ZERO, 0, 0, 5, 0, 0);
    send_fields(FN_SWAP, 8, 1, 0, 0, 0);
    send_fields(FN_SWAP, 1, 1023, 0, 0, 0);
    send_fields(FN_SET, 0, 0, 8, 32'h1, 0);
    send_fields(FN_RSVD6, 0, 0, 0, 0, 0);
    send_fields(FN_RSVD7, 1023, 1023, 1023, 32'hFFFF_FFFF, 1023);

    write_count(2047);                          // saturates to full size
    send_fields(FN_SWAP, 0, 1023, 0, 0, 0);
    send_fields(FN_SET, 0, 0, 1023, 32'h8000_0000, 0);
    send_fields(FN_RDPHY, 0, 0, 0, 0, 1023);
    send_fields(FN_RDVIS, 0, 0, 0, 0, 1022);
    send_fields(FN_RDVIS, 0, 0, 0, 0, 1023);

    counts = '{1024, 1, 2, 17, 40, 5, 1000, 12};
    total = 1880;
    sent = 0;
    for (int p = 0; p < 8; p++) begin
      write_count(counts[p]);
      for (int k = 0; k < total / 8; k++) begin
        if (sent == total / 3) begin
          send_idle_pct = 48;
          recv_idle_pct = 36;
        end else if (sent == 2 * total / 3) begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        if (k == 100) drain();                  // let everything come back
        send_cmd(random_cmd());
        sent++;
      end
    end
    write_count(0);
    send_fields(FN_ZERO, 0, 0, 0, 0, 0);
    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
